/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the compositor RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define GABC_ASSERT(lbl, clk_i, rstn_i, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define GABC_ASSERT_ALWAYS(lbl, clk_i, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* hw/rtl/gabc_pkg.sv */
// Shared types, constants and helpers for the gaussian alpha blend compositor.
// Used by gabc_ctrl, gabc_dp and the top level; depends on nothing.
package gabc_pkg;

  localparam int PixW  = 7;
  localparam int CtrW  = 16;
  localparam int ConW  = 24;
  localparam int Q8W   = 9;
  localparam int AccW  = 17;
  localparam int FracW = 8;
  // dx and dy: a 7-bit unsigned minus a 16-bit signed value.
  localparam int DW    = CtrW + 2;
  // Squares and the cross product of dx and dy stay below 2^31 in magnitude.
  localparam int SqW   = 32;
  // Quadratic form; each term stays well below 2^56.
  localparam int QW    = 58;

  localparam logic [Q8W-1:0] Q8_ONE   = 9'd256;
  localparam logic [Q8W-1:0] T_CUTOFF = 9'd4;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_SQR   = 8'b0000_0010,
    ST_TERM  = 8'b0000_0100,
    ST_SUM   = 8'b0000_1000,
    ST_WGT   = 8'b0001_0000,
    ST_ALPHA = 8'b0010_0000,
    ST_ACC   = 8'b0100_0000,
    ST_EMIT  = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic capture;
    logic sqr_en;
    logic term_en;
    logic sum_en;
    logic wgt_en;
    logic alpha_en;
    logic acc_en;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic out_busy;
  } sts_t;

  function automatic logic [Q8W-1:0] sat_q8(input logic [Q8W-1:0] v);
    return (v > Q8_ONE) ? Q8_ONE : v;
  endfunction

endpackage

/* hw/rtl/gabc_ctrl.sv */
// Sequencing state machine of the compositor: steps one item through the datapath.
// Depends on gabc_pkg.
module gabc_ctrl import gabc_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  sts_t   sts,
  output cmd_t   cmd
);

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = ST_SQR;
        end
      end
      ST_SQR: begin
        cmd.sqr_en = 1'b1;
        state_nxt  = ST_TERM;
      end
      ST_TERM: begin
        cmd.term_en = 1'b1;
        state_nxt   = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum_en = 1'b1;
        state_nxt  = ST_WGT;
      end
      ST_WGT: begin
        cmd.wgt_en = 1'b1;
        state_nxt  = ST_ALPHA;
      end
      ST_ALPHA: begin
        cmd.alpha_en = 1'b1;
        state_nxt    = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc_en = 1'b1;
        state_nxt  = sts.last ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        // Hold the finished pixel until the output register is free.
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hw/rtl/gabc_dp.sv */
// Datapath of the compositor: distance, weight, alpha, accumulators and output register.
// Depends on gabc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module gabc_dp import gabc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cmd_t                   cmd,
  output sts_t                   sts,
  input  logic [PixW-1:0]        in_pixel_x,
  input  logic [PixW-1:0]        in_pixel_y,
  input  logic signed [CtrW-1:0] in_center_x,
  input  logic signed [CtrW-1:0] in_center_y,
  input  logic signed [ConW-1:0] in_conic_a,
  input  logic signed [ConW-1:0] in_conic_b,
  input  logic signed [ConW-1:0] in_conic_c,
  input  logic [Q8W-1:0]         in_opacity,
  input  logic [Q8W-1:0]         in_color_red,
  input  logic [Q8W-1:0]         in_color_green,
  input  logic [Q8W-1:0]         in_color_blue,
  input  logic                   in_last,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [Q8W-1:0]         out_pixel_red,
  output logic [Q8W-1:0]         out_pixel_green,
  output logic [Q8W-1:0]         out_pixel_blue,
  output logic [Q8W-1:0]         out_final_transmittance
);

  // Captured item
  logic signed [DW-1:0]   dx_r, dy_r;
  logic signed [ConW-1:0] con_a_r, con_b_r, con_c_r;
  logic [Q8W-1:0]         op_r, col_r_r, col_g_r, col_b_r;
  logic                   last_r;

  // Distance pipeline registers
  logic signed [SqW-1:0]  dxx_r, dxy_r, dyy_r;
  logic signed [QW-1:0]   ta_r, tb_r, tc_r, q_r;
  logic [Q8W-1:0]         wt_r, alpha_r;

  // Pixel state
  logic [AccW-1:0]        acc_r_r, acc_g_r, acc_b_r;
  logic [AccW-1:0]        acc_r_nxt, acc_g_nxt, acc_b_nxt;
  logic [Q8W-1:0]         t_r, t_nxt;

  // Output register
  logic                   out_valid_r, out_valid_nxt;
  logic [Q8W-1:0]         out_red_r, out_green_r, out_blue_r, out_t_r;

  logic signed [DW-1:0]   dx_nxt, dy_nxt;
  logic signed [ConW+SqW-1:0] term_a, term_b, term_c;
  logic                   fp_hit;
  logic [FracW-1:0]       d2;
  logic [2*Q8W-1:0]       wprod, aprod, prod_r, prod_g, prod_b;
  logic [Q8W-1:0]         wt_nxt, alpha_nxt;
  logic                   pix_cleared;

  assign dx_nxt = $signed({{(DW-PixW){1'b0}}, in_pixel_x}) - DW'(in_center_x);
  assign dy_nxt = $signed({{(DW-PixW){1'b0}}, in_pixel_y}) - DW'(in_center_y);

  // Full-width conic terms, each a 24 by 32 bit signed product.
  assign term_a = con_a_r * dxx_r;
  assign term_b = con_b_r * dxy_r;
  assign term_c = con_c_r * dyy_r;

  // The footprint is 0 <= q < 2^16, i.e. 0 <= d2 < 256.
  assign fp_hit = !q_r[QW-1] && (q_r[QW-2:2*FracW] == '0);
  assign d2     = q_r[2*FracW-1:FracW];
  assign wprod  = op_r * (Q8_ONE - {1'b0, d2});
  assign wt_nxt = fp_hit ? wprod[FracW+Q8W-1:FracW] : '0;

  // An item that meets an almost opaque pixel contributes nothing.
  assign aprod     = wt_r * t_r;
  assign alpha_nxt = (t_r >= T_CUTOFF) ? aprod[FracW+Q8W-1:FracW] : '0;

  assign prod_r    = alpha_r * col_r_r;
  assign prod_g    = alpha_r * col_g_r;
  assign prod_b    = alpha_r * col_b_r;
  assign acc_r_nxt = acc_r_r + prod_r[AccW-1:0];
  assign acc_g_nxt = acc_g_r + prod_g[AccW-1:0];
  assign acc_b_nxt = acc_b_r + prod_b[AccW-1:0];
  assign t_nxt     = t_r - alpha_r;

  assign out_valid_nxt = cmd.emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      dx_r    <= dx_nxt;
      dy_r    <= dy_nxt;
      con_a_r <= in_conic_a;
      con_b_r <= in_conic_b;
      con_c_r <= in_conic_c;
      op_r    <= sat_q8(in_opacity);
      col_r_r <= sat_q8(in_color_red);
      col_g_r <= sat_q8(in_color_green);
      col_b_r <= sat_q8(in_color_blue);
      last_r  <= in_last;
    end
    if (cmd.sqr_en) begin
      dxx_r <= dx_r * dx_r;
      dxy_r <= dx_r * dy_r;
      dyy_r <= dy_r * dy_r;
    end
    if (cmd.term_en) begin
      ta_r <= QW'(term_a);
      tb_r <= QW'(term_b);
      tc_r <= QW'(term_c);
    end
    if (cmd.sum_en) begin
      q_r <= ta_r + (tb_r <<< 1) + tc_r;
    end
    if (cmd.wgt_en) begin
      wt_r <= wt_nxt;
    end
    if (cmd.alpha_en) begin
      alpha_r <= alpha_nxt;
    end
    if (cmd.emit) begin
      out_red_r   <= acc_r_r[AccW-1:FracW];
      out_green_r <= acc_g_r[AccW-1:FracW];
      out_blue_r  <= acc_b_r[AccW-1:FracW];
      out_t_r     <= t_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r_r     <= '0;
      acc_g_r     <= '0;
      acc_b_r     <= '0;
      t_r         <= Q8_ONE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd.emit) begin
        acc_r_r <= '0;
        acc_g_r <= '0;
        acc_b_r <= '0;
        t_r     <= Q8_ONE;
      end else if (cmd.acc_en) begin
        acc_r_r <= acc_r_nxt;
        acc_g_r <= acc_g_nxt;
        acc_b_r <= acc_b_nxt;
        t_r     <= t_nxt;
      end
    end
  end

  assign sts.last     = last_r;
  assign sts.out_busy = out_valid_r && !out_ready;

  assign out_valid               = out_valid_r;
  assign out_pixel_red           = out_red_r;
  assign out_pixel_green         = out_green_r;
  assign out_pixel_blue          = out_blue_r;
  assign out_final_transmittance = out_t_r;

  assign pix_cleared = out_valid_r && (t_r == Q8_ONE) && (acc_r_r == '0);

  `GABC_ASSERT(a_t_bounded, clk, rst_n, t_r <= Q8_ONE, "transmittance above one")
  `GABC_ASSERT(a_alpha_le_t, clk, rst_n, cmd.acc_en |-> alpha_r <= t_r, "alpha above T")
  `GABC_ASSERT(a_emit_clears, clk, rst_n, cmd.emit |=> pix_cleared, "pixel not cleared")

endmodule

/* hw/rtl/gaussian_alpha_blend_compositor.sv */
// Top level of the gaussian alpha blend compositor: controller plus datapath.
// Depends on gabc_pkg, gabc_ctrl and gabc_dp.
//
//   Channel  Direction  Handshake           Carries
//   in_      input      in_valid/in_ready   one depth-ordered gaussian for the pixel
//   out_     output     out_valid/out_ready composited colour and transmittance
//
// Each item passes through the squares, conic terms, sum, weight, alpha and accumulate
// steps of the datapath before in_ready rises again for the next item.
// An item marked last then adds an emit step to load the output register, which waits
// while an earlier result is still held there. Reset is synchronous and active low; it
// clears the accumulators, sets transmittance to one and empties the output.
module gaussian_alpha_blend_compositor import gabc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [PixW-1:0]        in_pixel_x,
  input  logic [PixW-1:0]        in_pixel_y,
  input  logic signed [CtrW-1:0] in_center_x,
  input  logic signed [CtrW-1:0] in_center_y,
  input  logic signed [ConW-1:0] in_conic_a,
  input  logic signed [ConW-1:0] in_conic_b,
  input  logic signed [ConW-1:0] in_conic_c,
  input  logic [Q8W-1:0]         in_opacity,
  input  logic [Q8W-1:0]         in_color_red,
  input  logic [Q8W-1:0]         in_color_green,
  input  logic [Q8W-1:0]         in_color_blue,
  input  logic                   in_last,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [Q8W-1:0]         out_pixel_red,
  output logic [Q8W-1:0]         out_pixel_green,
  output logic [Q8W-1:0]         out_pixel_blue,
  output logic [Q8W-1:0]         out_final_transmittance
);

  cmd_t cmd;
  sts_t sts;

  gabc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gabc_dp u_dp (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cmd                     (cmd),
    .sts                     (sts),
    .in_pixel_x              (in_pixel_x),
    .in_pixel_y              (in_pixel_y),
    .in_center_x             (in_center_x),
    .in_center_y             (in_center_y),
    .in_conic_a              (in_conic_a),
    .in_conic_b              (in_conic_b),
    .in_conic_c              (in_conic_c),
    .in_opacity              (in_opacity),
    .in_color_red            (in_color_red),
    .in_color_green          (in_color_green),
    .in_color_blue           (in_color_blue),
    .in_last                 (in_last),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_pixel_red           (out_pixel_red),
    .out_pixel_green         (out_pixel_green),
    .out_pixel_blue          (out_pixel_blue),
    .out_final_transmittance (out_final_transmittance)
  );

endmodule

/* tb/tb_gaussian_alpha_blend_compositor.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the gaussian alpha blend compositor: directed splats, then
// random depth-ordered splat lists, each checked against a front-to-back blending predictor.
// Depends on gabc_pkg and gaussian_alpha_blend_compositor.
module tb_gaussian_alpha_blend_compositor;
  import gabc_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 16;
  localparam longint FOOTPRINT = longint'(Q8_ONE) << FracW;

  typedef struct {
    logic [PixW-1:0]        pixel_x;
    logic [PixW-1:0]        pixel_y;
    logic signed [CtrW-1:0] center_x;
    logic signed [CtrW-1:0] center_y;
    logic signed [ConW-1:0] conic_a;
    logic signed [ConW-1:0] conic_b;
    logic signed [ConW-1:0] conic_c;
    logic [Q8W-1:0]         opacity;
    logic [Q8W-1:0]         color_red;
    logic [Q8W-1:0]         color_green;
    logic [Q8W-1:0]         color_blue;
    logic                   last;
  } splat_t;

  typedef struct {
    logic [Q8W-1:0] red;
    logic [Q8W-1:0] green;
    logic [Q8W-1:0] blue;
    logic [Q8W-1:0] trans;
  } pixel_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [PixW-1:0]        in_pixel_x = '0;
  logic [PixW-1:0]        in_pixel_y = '0;
  logic signed [CtrW-1:0] in_center_x = '0;
  logic signed [CtrW-1:0] in_center_y = '0;
  logic signed [ConW-1:0] in_conic_a = '0;
  logic signed [ConW-1:0] in_conic_b = '0;
  logic signed [ConW-1:0] in_conic_c = '0;
  logic [Q8W-1:0]         in_opacity = '0;
  logic [Q8W-1:0]         in_color_red = '0;
  logic [Q8W-1:0]         in_color_green = '0;
  logic [Q8W-1:0]         in_color_blue = '0;
  logic                   in_last = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [Q8W-1:0]         out_pixel_red;
  logic [Q8W-1:0]         out_pixel_green;
  logic [Q8W-1:0]         out_pixel_blue;
  logic [Q8W-1:0]         out_final_transmittance;

  // Blending state of the pixel under way, as the block should hold it.
  logic [AccW-1:0] acc_red = '0;
  logic [AccW-1:0] acc_green = '0;
  logic [AccW-1:0] acc_blue = '0;
  logic [Q8W-1:0]  trans_q8 = Q8_ONE;
  pixel_t          pixel_q[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int idle_cycles = 0;
  int n_errors = 0;
  int n_splats = 0;
  int n_pixels = 0;
  int n_blended = 0;
  int n_outside = 0;
  int n_opaque_skips = 0;

  gaussian_alpha_blend_compositor uut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_pixel_x             (in_pixel_x),
    .in_pixel_y             (in_pixel_y),
    .in_center_x            (in_center_x),
    .in_center_y            (in_center_y),
    .in_conic_a             (in_conic_a),
    .in_conic_b             (in_conic_b),
    .in_conic_c             (in_conic_c),
    .in_opacity             (in_opacity),
    .in_color_red           (in_color_red),
    .in_color_green         (in_color_green),
    .in_color_blue          (in_color_blue),
    .in_last                (in_last),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_pixel_red          (out_pixel_red),
    .out_pixel_green        (out_pixel_green),
    .out_pixel_blue         (out_pixel_blue),
    .out_final_transmittance(out_final_transmittance)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Anything with bit 8 set is at least one, so it clips to exactly one.
  function automatic logic [Q8W-1:0] q8_of(input logic [Q8W-1:0] v);
    return v[Q8W-1] ? Q8_ONE : v;
  endfunction

  task automatic blend_splat(input splat_t s);
    longint dx, dy, q, d2, wt, al;
    dx = longint'(s.pixel_x) - longint'(s.center_x);
    dy = longint'(s.pixel_y) - longint'(s.center_y);
    q = longint'(s.conic_a) * dx * dx + 2 * longint'(s.conic_b) * dx * dy
      + longint'(s.conic_c) * dy * dy;
    if (trans_q8 < T_CUTOFF) begin
      n_opaque_skips++;
    end else if (q < 0 || q >= FOOTPRINT) begin
      n_outside++;
    end else begin
      d2 = q >>> FracW;
      wt = (longint'(q8_of(s.opacity)) * (longint'(Q8_ONE) - d2)) >>> FracW;
      al = (wt * longint'(trans_q8)) >>> FracW;
      acc_red   = AccW'(longint'(acc_red) + al * longint'(q8_of(s.color_red)));
      acc_green = AccW'(longint'(acc_green) + al * longint'(q8_of(s.color_green)));
      acc_blue  = AccW'(longint'(acc_blue) + al * longint'(q8_of(s.color_blue)));
      trans_q8  = Q8W'(longint'(trans_q8) - al);
      n_blended++;
    end
    if (s.last) begin
      pixel_q.push_back('{Q8W'(acc_red >> FracW), Q8W'(acc_green >> FracW),
                          Q8W'(acc_blue >> FracW), trans_q8});
      acc_red = '0;
      acc_green = '0;
      acc_blue = '0;
      trans_q8 = Q8_ONE;
    end
  endtask

  task automatic check_field(input string name, input logic [Q8W-1:0] want, got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      n_errors++;
    end
  endtask

  // Checks results first, so that a result can never be matched against the splat that
  // is transferred at the same edge.
  always @(posedge clk) begin
    pixel_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pixel_q.size() == 0) begin
          $error("pixel result with none expected: %0d %0d %0d T=%0d", out_pixel_red,
                 out_pixel_green, out_pixel_blue, out_final_transmittance);
          n_errors++;
        end else begin
          want = pixel_q.pop_front();
          check_field("pixel_red", want.red, out_pixel_red);
          check_field("pixel_green", want.green, out_pixel_green);
          check_field("pixel_blue", want.blue, out_pixel_blue);
          check_field("final_transmittance", want.trans, out_final_transmittance);
          n_pixels++;
        end
      end
      if (in_valid && in_ready) begin
        blend_splat('{in_pixel_x, in_pixel_y, in_center_x, in_center_y, in_conic_a,
                      in_conic_b, in_conic_c, in_opacity, in_color_red, in_color_green,
                      in_color_blue, in_last});
        n_splats++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, pixel_q.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer, with valid
  // still high so that a following splat can go out back to back.
  task automatic send_splat(input splat_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_pixel_x = s.pixel_x;
    in_pixel_y = s.pixel_y;
    in_center_x = s.center_x;
    in_center_y = s.center_y;
    in_conic_a = s.conic_a;
    in_conic_b = s.conic_b;
    in_conic_c = s.conic_c;
    in_opacity = s.opacity;
    in_color_red = s.color_red;
    in_color_green = s.color_green;
    in_color_blue = s.color_blue;
    in_last = s.last;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  function automatic splat_t mk_splat(input int px, py, cx, cy, ca, cb, cc,
                                      input int op, cr, cg, cbl, input bit lst);
    return '{PixW'(px), PixW'(py), CtrW'(cx), CtrW'(cy), ConW'(ca), ConW'(cb), ConW'(cc),
             Q8W'(op), Q8W'(cr), Q8W'(cg), Q8W'(cbl), lst};
  endfunction

  function automatic int rand_q8();
    int r;
    r = $urandom_range(99);
    if (r < 6) return $urandom_range(257, 511);
    if (r < 12) return (r < 9) ? 256 : 0;
    return $urandom_range(0, 256);
  endfunction

  // Mostly splats centred a few pixels away with a modest conic, so that many land
  // inside the footprint; the rest are arbitrary bit patterns.
  function automatic splat_t rand_splat(input int px, py, input bit lst);
    if ($urandom_range(99) < 15)
      return mk_splat(px, py, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom, lst);
    return mk_splat(px, py, px + int'($urandom_range(0, 6)) - 3,
                    py + int'($urandom_range(0, 6)) - 3, $urandom_range(0, 6000),
                    int'($urandom_range(0, 4000)) - 2000, $urandom_range(0, 6000),
                    rand_q8(), rand_q8(), rand_q8(), rand_q8(), lst);
  endfunction

  task automatic test_empty_and_solid_pixels();
    send_splat(mk_splat(0, 0, 0, 0, 256, 0, 256, 0, 0, 0, 0, 1));
    // A fully opaque splat right on the pixel takes all of the transmittance.
    send_splat(mk_splat(127, 127, 127, 127, 256, 0, 256, 256, 256, 256, 256, 1));
  endtask

  task automatic test_footprint_bounds();
    send_splat(mk_splat(1, 0, 0, 0, 65535, 0, 0, 256, 256, 0, 0, 0));
    send_splat(mk_splat(1, 0, 0, 0, 65536, 0, 0, 256, 0, 256, 0, 0));
    send_splat(mk_splat(1, 0, 0, 0, -256, 0, 0, 256, 0, 0, 256, 0));
    send_splat(mk_splat(127, 127, -32768, -32768, 8388607, -8388608, 8388607,
                        256, 256, 256, 256, 0));
    send_splat(mk_splat(0, 127, 32767, -32768, 8388607, 0, 8388607, 256, 256, 256, 256, 0));
    send_splat(mk_splat(0, 0, 32767, 32767, -8388608, 8388607, -8388608,
                        256, 256, 256, 256, 1));
  endtask

  task automatic test_opaque_cutoff();
    // Transmittance drops to exactly the cut-off, which still blends, then to zero.
    send_splat(mk_splat(5, 9, 5, 9, 256, 0, 256, 252, 100, 200, 300, 0));
    send_splat(mk_splat(5, 9, 5, 9, 256, 0, 256, 256, 256, 0, 0, 0));
    send_splat(mk_splat(5, 9, 5, 9, 256, 0, 256, 256, 0, 256, 0, 1));
    // One below the cut-off: the final splat is skipped but still closes the pixel.
    send_splat(mk_splat(6, 9, 6, 9, 256, 0, 256, 253, 0, 0, 256, 0));
    send_splat(mk_splat(6, 9, 6, 9, 256, 0, 256, 256, 256, 256, 256, 1));
  endtask

  task automatic test_oversized_inputs();
    send_splat(mk_splat(64, 64, 63, 65, 512, -100, 512, 511, 511, 257, 384, 0));
    send_splat(mk_splat(64, 64, 64, 64, 256, 0, 256, 300, 0, 480, 256, 1));
  endtask

  task automatic test_random_pixels(input int n_items, sidle, ridle);
    int sent, len, px, py;
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
      px = $urandom_range(127);
      py = $urandom_range(127);
      for (int k = 0; k < len; k++)
        send_splat(rand_splat(px, py, k == len - 1));
      sent += len;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_and_solid_pixels();
    test_footprint_bounds();
    test_opaque_cutoff();
    test_oversized_inputs();
    test_random_pixels(533, 22, 78);
    test_random_pixels(533, 78, 22);
    test_random_pixels(534, 0, 0);
    in_valid = 1'b0;

    while (pixel_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d splats and checked %0d composited pixels.", n_splats, n_pixels);
    $display("Splats blended %0d, outside footprint %0d, dropped on opaque pixels %0d.",
             n_blended, n_outside, n_opaque_skips);
    if (n_errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/gabc_pkg.sv
hw/rtl/gabc_ctrl.sv
hw/rtl/gabc_dp.sv
hw/rtl/gaussian_alpha_blend_compositor.sv
tb/tb_gaussian_alpha_blend_compositor.sv
